@@ src/pfa_pkg.sv @@
// shared types, constants and codes for the page frame allocator
// no dependencies; the design files refer to it by scoped names, the testbench imports it
`default_nettype none

package pfa_pkg;

   localparam int NUM_PAGES  = 32768;
   localparam int COUNT_W    = 8;
   localparam int PAGE_SHIFT = 12;
   localparam int ADDR_W     = 27;
   localparam int KIND_W     = 3;
   localparam int STATUS_W   = 3;
   localparam int REFCNT_W   = 8;
   localparam int PAGE_W     = $clog2(NUM_PAGES);
   localparam int DEPTH_W    = $clog2(NUM_PAGES + 1);
   localparam int APAGE_W    = ADDR_W - PAGE_SHIFT;
   localparam int CSR_AW     = 3;
   localparam int CSR_DW     = 32;
   localparam int LOW_W      = 15;
   localparam int HIGH_W     = 16;

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
   localparam logic [PAGE_W-1:0]  PAGE_LAST = PAGE_W'(NUM_PAGES - 1);

   localparam logic [KIND_W-1:0] KIND_ALLOC  = 3'd0;
   localparam logic [KIND_W-1:0] KIND_FREE   = 3'd1;
   localparam logic [KIND_W-1:0] KIND_INC    = 3'd2;
   localparam logic [KIND_W-1:0] KIND_DEC    = 3'd3;
   localparam logic [KIND_W-1:0] KIND_QUERY  = 3'd4;
   localparam logic [KIND_W-1:0] KIND_DONATE = 3'd5;

   localparam logic [STATUS_W-1:0] STAT_OK    = 3'd0;
   localparam logic [STATUS_W-1:0] STAT_OOM   = 3'd1;
   localparam logic [STATUS_W-1:0] STAT_BAD   = 3'd2;
   localparam logic [STATUS_W-1:0] STAT_UNDER = 3'd3;
   localparam logic [STATUS_W-1:0] STAT_OVER  = 3'd4;

   localparam logic CSR_LOW_PAGE  = 1'b0;
   localparam logic CSR_HIGH_PAGE = 1'b1;

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_EXEC
   } state_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [ADDR_W-1:0] address;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0]   page_address;
      logic [STATUS_W-1:0] status;
      logic [REFCNT_W-1:0] ref_count;
      logic                page_released;
   } rsp_type;

   typedef struct packed {
      logic              en;
      logic [PAGE_W-1:0] addr;
      logic [COUNT_W-1:0] data;
   } cnt_wr_type;

   typedef struct packed {
      logic              en;
      logic [PAGE_W-1:0] addr;
      logic [PAGE_W-1:0] data;
   } stk_wr_type;

endpackage

`default_nettype wire

@@ src/pfa_csr.sv @@
// apb register block holding the managed page window
// depends on pfa_pkg
`default_nettype none

module pfa_csr (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      csr_psel,
   input  wire logic                      csr_penable,
   input  wire logic                      csr_pwrite,
   input  wire logic [pfa_pkg::CSR_AW-1:0] csr_paddr,
   input  wire logic [pfa_pkg::CSR_DW-1:0] csr_pwdata,
   output logic      [pfa_pkg::CSR_DW-1:0] csr_prdata,
   output logic                           csr_pready,
   output logic      [pfa_pkg::LOW_W-1:0]  low_page,
   output logic      [pfa_pkg::HIGH_W-1:0] high_page
);

   logic [pfa_pkg::LOW_W-1:0]  low_ff;
   logic [pfa_pkg::HIGH_W-1:0] high_ff;
   logic                       wr_en;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff  <= '0;
         high_ff <= pfa_pkg::HIGH_W'(pfa_pkg::NUM_PAGES);
      end else if (wr_en) begin
         case (csr_paddr[2])
            pfa_pkg::CSR_LOW_PAGE:  low_ff  <= csr_pwdata[pfa_pkg::LOW_W-1:0];
            pfa_pkg::CSR_HIGH_PAGE: high_ff <= csr_pwdata[pfa_pkg::HIGH_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         pfa_pkg::CSR_LOW_PAGE:  csr_prdata = pfa_pkg::CSR_DW'(low_ff);
         pfa_pkg::CSR_HIGH_PAGE: csr_prdata = pfa_pkg::CSR_DW'(high_ff);
         default:                csr_prdata = '0;
      endcase
   end

   assign low_page  = low_ff;
   assign high_page = high_ff;

endmodule

`default_nettype wire

@@ src/pfa_cnt_ram.sv @@
// reference count memory, one entry per page, registered read
// depends on pfa_pkg
`default_nettype none

module pfa_cnt_ram (
   input  wire logic                        clock,
   input  wire logic                        rd_en,
   input  wire logic [pfa_pkg::PAGE_W-1:0]  rd_addr,
   output logic      [pfa_pkg::COUNT_W-1:0] rd_data,
   input  wire pfa_pkg::cnt_wr_type         wr
);

   logic [pfa_pkg::COUNT_W-1:0] mem [pfa_pkg::NUM_PAGES];
   logic [pfa_pkg::COUNT_W-1:0] rd_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      if (rd_en) begin
         rd_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_ff;

endmodule

`default_nettype wire

@@ src/pfa_stack_ram.sv @@
// free page stack memory, registered read
// depends on pfa_pkg
`default_nettype none

module pfa_stack_ram (
   input  wire logic                       clock,
   input  wire logic                       rd_en,
   input  wire logic [pfa_pkg::PAGE_W-1:0] rd_addr,
   output logic      [pfa_pkg::PAGE_W-1:0] rd_data,
   input  wire pfa_pkg::stk_wr_type        wr
);

   logic [pfa_pkg::PAGE_W-1:0] mem [pfa_pkg::NUM_PAGES];
   logic [pfa_pkg::PAGE_W-1:0] rd_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      if (rd_en) begin
         rd_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_ff;

endmodule

`default_nettype wire

@@ src/refcounted_page_frame_allocator.sv @@
// top level: request sequencer around the count and free stack memories
// depends on pfa_pkg, pfa_csr, pfa_cnt_ram, pfa_stack_ram
//
//   port group   direction  handshake         beat
//   req_         in         valid / stall     kind, address
//   rsp_         out        valid / stall     page_address, status, ref_count, page_released
//   csr_         in/out     apb setup/access  low_page, high_page
//
// memories are read at the accept edge; the result is written back and registered
// from the exec state once the reply register is free
// after reset a clearing pass zeroes the count memory, no requests taken
// a stalled result holds the write-back step; no new request enters while it waits
`default_nettype none

module refcounted_page_frame_allocator (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire pfa_pkg::req_type              req_beat,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output pfa_pkg::rsp_type                   rsp_beat,
   input  wire logic                          csr_psel,
   input  wire logic                          csr_penable,
   input  wire logic                          csr_pwrite,
   input  wire logic [pfa_pkg::CSR_AW-1:0]    csr_paddr,
   input  wire logic [pfa_pkg::CSR_DW-1:0]    csr_pwdata,
   output logic      [pfa_pkg::CSR_DW-1:0]    csr_prdata,
   output logic                               csr_pready
);

   pfa_pkg::state_type            state_ff, state_in;
   pfa_pkg::req_type              req_ff;
   logic [pfa_pkg::DEPTH_W-1:0]   depth_ff, depth_in;
   logic [pfa_pkg::PAGE_W-1:0]    clr_idx_ff, clr_idx_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   pfa_pkg::rsp_type              rsp_ff, rsp_in;

   logic [pfa_pkg::LOW_W-1:0]     low_page;
   logic [pfa_pkg::HIGH_W-1:0]    high_page;
   logic [pfa_pkg::COUNT_W-1:0]   cnt_rd;
   logic [pfa_pkg::PAGE_W-1:0]    stk_rd;
   pfa_pkg::cnt_wr_type           cnt_wr, cnt_op;
   pfa_pkg::stk_wr_type           stk_wr;
   logic                          accept, out_free, exec_go;
   logic [pfa_pkg::APAGE_W-1:0]   req_page, page;
   logic [pfa_pkg::PAGE_W-1:0]    page_idx;
   logic                          in_range, free_ok, can_push;
   pfa_pkg::rsp_type              res;
   logic                          push_req;

   pfa_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .low_page    (low_page),
      .high_page   (high_page)
   );

   assign req_page = req_beat.address[pfa_pkg::ADDR_W-1:pfa_pkg::PAGE_SHIFT];

   pfa_cnt_ram u_cnt_ram (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (pfa_pkg::PAGE_W'(req_page)),
      .rd_data (cnt_rd),
      .wr      (cnt_wr)
   );

   pfa_stack_ram u_stack_ram (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (pfa_pkg::PAGE_W'(depth_ff - pfa_pkg::DEPTH_W'(1))),
      .rd_data (stk_rd),
      .wr      (stk_wr)
   );

   assign req_stall = (state_ff != pfa_pkg::S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign exec_go   = (state_ff == pfa_pkg::S_EXEC) && out_free;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pfa_pkg::S_CLEAR: begin
            if (clr_idx_ff == pfa_pkg::PAGE_LAST) state_in = pfa_pkg::S_IDLE;
         end
         pfa_pkg::S_IDLE: begin
            if (req_valid) state_in = pfa_pkg::S_EXEC;
         end
         pfa_pkg::S_EXEC: begin
            if (out_free) state_in = pfa_pkg::S_IDLE;
         end
         default: state_in = pfa_pkg::S_IDLE;
      endcase
   end

   // request evaluation
   assign page     = req_ff.address[pfa_pkg::ADDR_W-1:pfa_pkg::PAGE_SHIFT];
   assign page_idx = pfa_pkg::PAGE_W'(page);
   assign in_range = ({1'b0, page} < (pfa_pkg::APAGE_W + 1)'(pfa_pkg::NUM_PAGES));
   assign free_ok  = (req_ff.address[pfa_pkg::PAGE_SHIFT-1:0] == '0)
                     && (page >= pfa_pkg::APAGE_W'(low_page))
                     && ({1'b0, page} < (pfa_pkg::APAGE_W + 1)'(high_page))
                     && in_range;
   assign can_push = (depth_ff < pfa_pkg::DEPTH_W'(pfa_pkg::NUM_PAGES));

   always_comb begin
      res.page_address  = req_ff.address;
      res.status        = pfa_pkg::STAT_OK;
      res.ref_count     = '0;
      res.page_released = 1'b0;
      cnt_op            = '{en: 1'b0, addr: page_idx, data: cnt_rd};
      push_req          = 1'b0;
      depth_in          = depth_ff;
      case (req_ff.kind)
         pfa_pkg::KIND_ALLOC: begin
            if (depth_ff == '0) begin
               res.page_address = '0;
               res.status       = pfa_pkg::STAT_OOM;
            end else begin
               depth_in         = depth_ff - pfa_pkg::DEPTH_W'(1);
               cnt_op           = '{en: 1'b1, addr: stk_rd,
                                    data: pfa_pkg::COUNT_W'(1)};
               res.page_address = pfa_pkg::ADDR_W'({stk_rd, {pfa_pkg::PAGE_SHIFT{1'b0}}});
               res.ref_count    = pfa_pkg::REFCNT_W'(1);
            end
         end
         pfa_pkg::KIND_FREE: begin
            if (!free_ok) begin
               res.status = pfa_pkg::STAT_BAD;
            end else if (cnt_rd == '0) begin
               res.status = pfa_pkg::STAT_UNDER;
            end else begin
               cnt_op.en     = 1'b1;
               cnt_op.data   = cnt_rd - pfa_pkg::COUNT_W'(1);
               res.ref_count = pfa_pkg::REFCNT_W'(cnt_op.data);
               push_req      = (cnt_op.data == '0);
            end
         end
         pfa_pkg::KIND_DONATE: begin
            if (!free_ok) begin
               res.status = pfa_pkg::STAT_BAD;
            end else if (cnt_rd == pfa_pkg::COUNT_MAX) begin
               res.status    = pfa_pkg::STAT_OVER;
               res.ref_count = pfa_pkg::REFCNT_W'(cnt_rd);
            end else if (cnt_rd == '0) begin
               push_req = 1'b1;
            end else begin
               res.ref_count = pfa_pkg::REFCNT_W'(cnt_rd);
            end
         end
         pfa_pkg::KIND_INC: begin
            if (!in_range) begin
               res.status = pfa_pkg::STAT_BAD;
            end else if (cnt_rd == pfa_pkg::COUNT_MAX) begin
               res.status    = pfa_pkg::STAT_OVER;
               res.ref_count = pfa_pkg::REFCNT_W'(cnt_rd);
            end else begin
               cnt_op.en     = 1'b1;
               cnt_op.data   = cnt_rd + pfa_pkg::COUNT_W'(1);
               res.ref_count = pfa_pkg::REFCNT_W'(cnt_op.data);
            end
         end
         pfa_pkg::KIND_DEC: begin
            if (!in_range) begin
               res.status = pfa_pkg::STAT_BAD;
            end else if (cnt_rd == '0) begin
               res.status = pfa_pkg::STAT_UNDER;
            end else begin
               cnt_op.en     = 1'b1;
               cnt_op.data   = cnt_rd - pfa_pkg::COUNT_W'(1);
               res.ref_count = pfa_pkg::REFCNT_W'(cnt_op.data);
            end
         end
         pfa_pkg::KIND_QUERY: begin
            if (!in_range) begin
               res.status = pfa_pkg::STAT_BAD;
            end else begin
               res.ref_count = pfa_pkg::REFCNT_W'(cnt_rd);
            end
         end
         default: ;
      endcase
      if (push_req && can_push) begin
         res.page_released = 1'b1;
         depth_in          = depth_ff + pfa_pkg::DEPTH_W'(1);
      end
   end

   // memory write ports and register updates
   always_comb begin
      stk_wr = '{en: exec_go && res.page_released,
                 addr: pfa_pkg::PAGE_W'(depth_ff), data: page_idx};
      if (state_ff == pfa_pkg::S_CLEAR) begin
         cnt_wr = '{en: 1'b1, addr: clr_idx_ff, data: '0};
      end else begin
         cnt_wr    = cnt_op;
         cnt_wr.en = cnt_op.en && exec_go;
      end
      clr_idx_in   = (state_ff == pfa_pkg::S_CLEAR) ? clr_idx_ff + pfa_pkg::PAGE_W'(1)
                                                    : clr_idx_ff;
      rsp_in       = exec_go ? res : rsp_ff;
      rsp_valid_in = exec_go || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pfa_pkg::S_CLEAR;
         depth_ff     <= '0;
         clr_idx_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_idx_ff   <= clr_idx_in;
         rsp_valid_ff <= rsp_valid_in;
         if (exec_go) depth_ff <= depth_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) req_ff <= req_beat;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_beat  = rsp_ff;

endmodule

`default_nettype wire

@@ src/pfa_checker.sv @@
// port-level checks for the page frame allocator, bound to the top level
// depends on pfa_pkg and refcounted_page_frame_allocator
`default_nettype none

module pfa_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_stall,
   input wire logic             rsp_valid,
   input wire logic             rsp_stall,
   input wire pfa_pkg::rsp_type rsp_beat
);

   // a stalled result beat is not withdrawn
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp beat dropped while stalled");

   // one request at a time: no accept on the cycle after an accept
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted back to back");

   // out of memory returns no page
   a_oom_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_beat.status == pfa_pkg::STAT_OOM |->
      rsp_beat.page_address == '0 && rsp_beat.ref_count == '0)
      else $error("out of memory beat carries a page");

   // a released page has a zero count and ok status
   a_release_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_beat.page_released |->
      rsp_beat.status == pfa_pkg::STAT_OK && rsp_beat.ref_count == '0)
      else $error("page released with nonzero count or error");

   // bad address changes nothing
   a_bad_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_beat.status == pfa_pkg::STAT_BAD |->
      rsp_beat.ref_count == '0 && !rsp_beat.page_released)
      else $error("bad address beat shows a count or release");

endmodule

bind refcounted_page_frame_allocator pfa_checker u_pfa_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_beat  (rsp_beat)
);

`default_nettype wire

@@ sim/tb.sv @@
// testbench for refcounted_page_frame_allocator: random and directed requests with a
// self-checking frame ledger that predicts every reply beat; depends on pfa_pkg and the dut
`timescale 1ns / 100ps

module tb;
   import pfa_pkg::*;

   localparam logic [KIND_W-1:0] KIND_RSVD_A = 3'd6;
   localparam logic [KIND_W-1:0] KIND_RSVD_B = 3'd7;
   localparam int STALL_LIMIT   = 200000;
   localparam int SETTLE_CYCLES = 8;
   localparam int POOL_SIZE     = 12;

   class frame_ledger;
      logic [COUNT_W-1:0] page_count [NUM_PAGES];
      logic [PAGE_W-1:0]  free_pages [NUM_PAGES];
      int                 free_top;
      logic [LOW_W-1:0]   low_bound;
      logic [HIGH_W-1:0]  high_bound;
      logic [ADDR_W-1:0]  last_grant;
      rsp_type            due_replies [$];
      int                 errors;

      function new();
         foreach (page_count[i]) page_count[i] = '0;
         free_top = 0;
         low_bound = '0;
         high_bound = HIGH_W'(NUM_PAGES);
         last_grant = '0;
         errors = 0;
      endfunction

      function void set_bound(logic idx, logic [CSR_DW-1:0] value);
         if (idx == CSR_LOW_PAGE) low_bound = value[LOW_W-1:0];
         else high_bound = value[HIGH_W-1:0];
      endfunction

      function logic push_frame(logic [PAGE_W-1:0] pg);
         if (free_top >= NUM_PAGES) return 1'b0;
         free_pages[free_top] = pg;
         free_top++;
         return 1'b1;
      endfunction

      function rsp_type predict_reply(req_type r);
         rsp_type            o;
         logic [APAGE_W-1:0] pg;
         logic [COUNT_W-1:0] c;
         logic               in_window;
         pg = r.address[ADDR_W-1:PAGE_SHIFT];
         c = page_count[pg];
         o.page_address = r.address;
         o.status = STAT_OK;
         o.ref_count = '0;
         o.page_released = 1'b0;
         in_window = (r.address[PAGE_SHIFT-1:0] == '0) && (pg >= low_bound)
                     && ({1'b0, pg} < high_bound) && (int'(pg) < NUM_PAGES);
         case (r.kind)
            KIND_ALLOC: begin
               if (free_top == 0) begin
                  o.page_address = '0;
                  o.status = STAT_OOM;
               end else begin
                  free_top--;
                  pg = free_pages[free_top];
                  page_count[pg] = COUNT_W'(1);
                  o.page_address = {pg, {PAGE_SHIFT{1'b0}}};
                  o.ref_count = REFCNT_W'(1);
               end
               last_grant = o.page_address;
            end
            KIND_FREE: begin
               if (!in_window) o.status = STAT_BAD;
               else if (c == 0) o.status = STAT_UNDER;
               else begin
                  c--;
                  page_count[pg] = c;
                  o.ref_count = REFCNT_W'(c);
                  if (c == 0) o.page_released = push_frame(pg);
               end
            end
            KIND_DONATE: begin
               if (!in_window) o.status = STAT_BAD;
               else if (c == COUNT_MAX) begin
                  o.status = STAT_OVER;
                  o.ref_count = REFCNT_W'(c);
               end else if (c == 0) o.page_released = push_frame(pg);
               else o.ref_count = REFCNT_W'(c);
            end
            KIND_INC, KIND_DEC, KIND_QUERY: begin
               if (int'(pg) >= NUM_PAGES) o.status = STAT_BAD;
               else begin
                  if (r.kind == KIND_INC) begin
                     if (c == COUNT_MAX) o.status = STAT_OVER;
                     else c++;
                  end else if (r.kind == KIND_DEC) begin
                     if (c == 0) o.status = STAT_UNDER;
                     else c--;
                  end
                  page_count[pg] = c;
                  o.ref_count = REFCNT_W'(c);
               end
            end
            default: ;
         endcase
         return o;
      endfunction

      function void log_request(req_type r);
         due_replies.push_back(predict_reply(r));
      endfunction

      function void compare(string field, logic [63:0] want, logic [63:0] got);
         if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
            errors++;
         end
      endfunction

      function void check_reply(rsp_type got);
         rsp_type want;
         if (due_replies.size() == 0) begin
            $error("reply beat with nothing outstanding: 0x%0h", got);
            errors++;
            return;
         end
         want = due_replies.pop_front();
         compare("page_address", 64'(want.page_address), 64'(got.page_address));
         compare("status", 64'(want.status), 64'(got.status));
         compare("ref_count", 64'(want.ref_count), 64'(got.ref_count));
         compare("page_released", 64'(want.page_released), 64'(got.page_released));
      endfunction

      function int pending();
         return due_replies.size();
      endfunction

      function int zero_page(int start);
         for (int p = start; p < NUM_PAGES; p++)
            if (page_count[p] == 0) return p;
         return start;
      endfunction

      function int close_out();
         foreach (due_replies[i]) begin
            $error("reply never arrived: 0x%0h", due_replies[i]);
            errors++;
         end
         return errors;
      endfunction
   endclass

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   req_type             req_beat;
   logic                rsp_valid;
   logic                rsp_stall;
   rsp_type             rsp_beat;
   logic                csr_psel;
   logic                csr_penable;
   logic                csr_pwrite;
   logic [CSR_AW-1:0]   csr_paddr;
   logic [CSR_DW-1:0]   csr_pwdata;
   logic [CSR_DW-1:0]   csr_prdata;
   logic                csr_pready;

   frame_ledger         ledger;
   bit                  quiet;
   int                  idle_cycles;
   int                  page_pool [POOL_SIZE];

   refcounted_page_frame_allocator dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_beat(req_beat),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_beat(rsp_beat),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) ledger.check_reply(rsp_beat);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   // reply side backpressure
   initial begin
      int n;
      wait (!reset);
      forever begin
         n = quiet ? 0 : $urandom_range(0, 11);
         rsp_stall <= (n != 0);
         if (n != 0) begin
            repeat (n) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (!(rsp_valid === 1'b1) || rsp_stall);
      end
   end

   task automatic send_request(input logic [KIND_W-1:0] kind,
                               input logic [ADDR_W-1:0] address);
      int      gap;
      req_type beat;
      gap = quiet ? 0 : $urandom_range(0, 11);
      beat.kind = kind;
      beat.address = address;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_beat <= beat;
      do @(posedge clock); while (req_stall !== 1'b0);
      ledger.log_request(beat);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (ledger.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [CSR_DW-1:0] value);
      logic [CSR_DW-1:0] kept;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      csr_pwrite <= 1'b1;
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      ledger.set_bound(idx, value);
      // read back
      csr_pwrite <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      kept = (idx == CSR_LOW_PAGE) ? CSR_DW'(value[LOW_W-1:0]) : CSR_DW'(value[HIGH_W-1:0]);
      ledger.compare("csr_prdata", 64'(kept), 64'(csr_prdata));
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_window(input int low, input int high);
      int span;
      settle();
      write_csr(CSR_LOW_PAGE, CSR_DW'(low));
      write_csr(CSR_HIGH_PAGE, CSR_DW'(high));
      page_pool[0] = low;
      page_pool[1] = (high > 0) ? high - 1 : 0;
      page_pool[2] = (low > 0) ? low - 1 : 0;
      page_pool[3] = (high < NUM_PAGES) ? high : NUM_PAGES - 1;
      span = (high > low) ? high - low : 1;
      for (int i = 4; i < POOL_SIZE; i++)
         page_pool[i] = (high > low) ? low + $urandom_range(0, span - 1)
                                     : $urandom_range(0, NUM_PAGES - 1);
   endtask

   function automatic logic [KIND_W-1:0] pick_kind();
      int r;
      r = $urandom_range(0, 19);
      if (r < 4) return KIND_ALLOC;
      if (r < 8) return KIND_FREE;
      if (r < 12) return KIND_INC;
      if (r < 14) return KIND_DEC;
      if (r < 16) return KIND_QUERY;
      if (r < 19) return KIND_DONATE;
      return $urandom_range(0, 1) ? KIND_RSVD_A : KIND_RSVD_B;
   endfunction

   function automatic logic [ADDR_W-1:0] pick_address();
      int                 r;
      logic [APAGE_W-1:0] pg;
      r = $urandom_range(0, 9);
      pg = APAGE_W'(page_pool[$urandom_range(0, POOL_SIZE - 1)]);
      if (r == 6) return {pg, PAGE_SHIFT'($urandom_range(1, 4095))};
      if (r == 7) return ADDR_W'($urandom);
      if (r == 9) return {APAGE_W'($urandom), {PAGE_SHIFT{1'b0}}};
      return {pg, {PAGE_SHIFT{1'b0}}};
   endfunction

   task automatic run_mix(input int count);
      logic [ADDR_W-1:0] grant;
      int                done;
      done = 0;
      while (done < count) begin
         if ($urandom_range(0, 39) == 0) quiet = !quiet;
         if ($urandom_range(0, 5) == 0) begin
            // page lifetime: take, share, drop twice
            send_request(KIND_ALLOC, ADDR_W'($urandom));
            grant = ledger.last_grant;
            send_request(KIND_INC, grant);
            send_request(KIND_FREE, grant);
            send_request(KIND_FREE, grant);
            done += 4;
         end else begin
            send_request(pick_kind(), pick_address());
            done++;
         end
      end
   endtask

   initial begin
      logic [ADDR_W-1:0] hot;
      ledger = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req_beat = '0;
      rsp_stall = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      quiet = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      set_window(0, NUM_PAGES);
      send_request(KIND_ALLOC, 27'h7FFFFFF);
      send_request(KIND_FREE, 27'h5000);
      send_request(KIND_DEC, 27'h5000);
      send_request(KIND_QUERY, 27'h5000);
      send_request(KIND_INC, 27'h5000);
      send_request(KIND_INC, 27'h5000);
      send_request(KIND_FREE, 27'h5001);
      send_request(KIND_DONATE, 27'h5FFF);
      send_request(KIND_DONATE, 27'h3000);
      send_request(KIND_DONATE, 27'h5000);
      send_request(KIND_ALLOC, 27'h0);
      send_request(KIND_FREE, 27'h3000);
      send_request(KIND_FREE, 27'h5000);
      send_request(KIND_RSVD_A, 27'h7FFFFFF);
      send_request(KIND_RSVD_B, 27'h0);
      send_request(KIND_QUERY, 27'h7FFFFFF);
      send_request(KIND_INC, 27'h7FFF000);
      send_request(KIND_DONATE, 27'h7FFF000);
      send_request(KIND_FREE, 27'h7FFF000);
      send_request(KIND_DONATE, 27'h0);
      send_request(KIND_ALLOC, 27'h5A5A5A5);
      set_window(10, 20);
      send_request(KIND_FREE, 27'h9000);
      send_request(KIND_DONATE, 27'h14000);
      send_request(KIND_DONATE, 27'h13000);
      send_request(KIND_DONATE, 27'hA000);

      // drive one page to saturation and past it, then decrement it three times
      set_window(0, NUM_PAGES);
      hot = {APAGE_W'(ledger.zero_page(64)), {PAGE_SHIFT{1'b0}}};
      repeat (COUNT_MAX + 3) send_request(KIND_INC, hot);
      send_request(KIND_DONATE, hot);
      send_request(KIND_QUERY, hot);
      repeat (3) send_request(KIND_DEC, hot);
      run_mix(150);

      set_window(NUM_PAGES - 1, NUM_PAGES);
      run_mix(150);
      set_window(0, 1);
      run_mix(150);
      set_window(100, 200);
      run_mix(150);
      set_window($urandom_range(0, NUM_PAGES - 1), $urandom_range(1, NUM_PAGES));
      run_mix(150);
      set_window($urandom_range(0, NUM_PAGES - 1), $urandom_range(1, NUM_PAGES));
      run_mix(100);

      set_window(0, NUM_PAGES);
      repeat (4) send_request(KIND_ALLOC, ADDR_W'($urandom));
      run_mix(60);

      settle();
      if (ledger.close_out() == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

endmodule
